// ===== src/mwire_pkg.sv =====
package mwire_pkg;

	// One timebase tick with an optional command
	typedef struct packed {
		logic [2:0]  operation;
		logic [7:0]  word_address;
		logic [15:0] write_data;
		logic        miso_level;
	} cmd_t;

	// Pin levels and status after one tick
	typedef struct packed {
		logic        chip_select;
		logic        serial_clock;
		logic        serial_data_out;
		logic        busy_res;
		logic        done_res;
		logic [15:0] rd_word;
		logic        status;
	} pins_t;

	typedef enum logic [5:0] {
		PH_IDLE       = 6'b000001,
		PH_SEND       = 6'b000010,
		PH_RECV       = 6'b000100,
		PH_TRAIL_POLL = 6'b001000,
		PH_POLL       = 6'b010000,
		PH_TRAIL_DONE = 6'b100000
	} phase_t;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_READ  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_WREN  = 3'd3;
	localparam logic [2:0] OP_WRDS  = 3'd4;

	// Start bit plus opcode
	localparam logic [2:0] HDR_READ  = 3'b110;
	localparam logic [2:0] HDR_WRITE = 3'b101;
	localparam logic [2:0] HDR_MISC  = 3'b100;
	localparam logic [1:0] SUB_WREN  = 2'b11;
	localparam logic [1:0] SUB_WRDS  = 2'b00;

	localparam int DATA_BITS  = 16;
	localparam int TRAIL_BITS = 2;

	localparam logic       CFG_HALF_TICKS = 1'b0;
	localparam logic       CFG_POLL_LIMIT = 1'b1;
	localparam logic [9:0] HALF_RESET     = 10'd125;
	localparam logic [7:0] POLL_RESET     = 8'd100;

endpackage

// ===== src/mwire_seq.sv =====
module mwire_seq import mwire_pkg::*; #(
	parameter int ADDR_BITS       = 8,
	parameter int POLL_GROUP_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       step,
	input  cmd_t       cmd,
	output pins_t      pins_next
);

	localparam int SHIFT_W = 3 + ADDR_BITS + DATA_BITS;
	localparam int BL_MAX  = (SHIFT_W > POLL_GROUP_BITS) ? SHIFT_W : POLL_GROUP_BITS;
	localparam int BL_W    = $clog2(BL_MAX + 1);
	localparam int IDX_W   = $clog2(SHIFT_W);

	localparam logic [BL_W-1:0] HDR_LEN   = BL_W'(3 + ADDR_BITS);
	localparam logic [BL_W-1:0] WR_LEN    = BL_W'(SHIFT_W);
	localparam logic [BL_W-1:0] RECV_LEN  = BL_W'(DATA_BITS);
	localparam logic [BL_W-1:0] TRAIL_LEN = BL_W'(TRAIL_BITS);
	localparam logic [BL_W-1:0] POLL_LEN  = BL_W'(POLL_GROUP_BITS);

	logic [9:0]         half_ticks_q;
	logic [7:0]         poll_limit_q;
	phase_t             phase_q, phase_n;
	logic [SHIFT_W-1:0] shift_q, shift_n;
	logic [BL_W-1:0]    bits_q, bits_n, bits_dec;
	logic [15:0]        rx_q, rx_n;
	logic [7:0]         poll_q, poll_n, poll_inc;
	logic [9:0]         div_q, div_n, div_inc;
	logic               half_q, half_n;
	logic               status_q, status_n;
	logic [15:0]        word_q, word_n;
	logic [2:0]         op_q, op_n;
	logic               done_n;
	logic [IDX_W-1:0]   mosi_idx;
	logic [ADDR_BITS-1:0] addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_ticks_q <= HALF_RESET;
			poll_limit_q <= POLL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HALF_TICKS: half_ticks_q <= cfg_data;
				CFG_POLL_LIMIT: poll_limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign addr     = cmd.word_address[ADDR_BITS-1:0];
	assign div_inc  = div_q + 10'd1;
	assign poll_inc = poll_q + 8'd1;
	assign bits_dec = (bits_q != '0) ? bits_q - BL_W'(1) : bits_q;

	always_comb begin
		phase_n  = phase_q;
		shift_n  = shift_q;
		bits_n   = bits_q;
		rx_n     = rx_q;
		poll_n   = poll_q;
		div_n    = div_q;
		half_n   = half_q;
		status_n = status_q;
		word_n   = word_q;
		op_n     = op_q;
		done_n   = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (cmd.operation == OP_READ || cmd.operation == OP_WRITE ||
			    cmd.operation == OP_WREN || cmd.operation == OP_WRDS) begin
				op_n     = cmd.operation;
				status_n = 1'b0;
				poll_n   = '0;
				phase_n  = PH_SEND;
				bits_n   = HDR_LEN;
				div_n    = '0;
				half_n   = 1'b0;
				rx_n     = '0;
				unique case (cmd.operation)
					OP_READ: shift_n = SHIFT_W'({HDR_READ, addr});
					OP_WRITE: begin
						shift_n = {HDR_WRITE, addr, cmd.write_data};
						bits_n  = WR_LEN;
					end
					OP_WREN: shift_n = SHIFT_W'({HDR_MISC, SUB_WREN, (ADDR_BITS-2)'(0)});
					default: shift_n = SHIFT_W'({HDR_MISC, SUB_WRDS, (ADDR_BITS-2)'(0)});
				endcase
			end
		end else if (div_inc != half_ticks_q) begin
			div_n = div_inc;
		end else begin
			div_n = '0;
			if (!half_q) begin
				half_n = 1'b1;
			end else begin
				// end of a serial bit: sample MISO at the close of the high half
				half_n = 1'b0;
				rx_n   = {rx_q[14:0], cmd.miso_level};
				bits_n = bits_dec;
				if (bits_dec == '0) begin
					rx_n = '0;
					unique case (phase_q)
						PH_SEND: begin
							if (op_q == OP_READ) begin
								phase_n = PH_RECV;
								bits_n  = RECV_LEN;
							end else if (op_q == OP_WRITE) begin
								phase_n = PH_TRAIL_POLL;
								bits_n  = TRAIL_LEN;
							end else begin
								phase_n = PH_TRAIL_DONE;
								bits_n  = TRAIL_LEN;
							end
						end
						PH_RECV: begin
							word_n  = {rx_q[14:0], cmd.miso_level};
							phase_n = PH_TRAIL_DONE;
							bits_n  = TRAIL_LEN;
						end
						PH_TRAIL_POLL: begin
							phase_n = PH_POLL;
							bits_n  = POLL_LEN;
						end
						PH_POLL: begin
							if (cmd.miso_level) begin
								phase_n = PH_TRAIL_DONE;
								bits_n  = TRAIL_LEN;
							end else begin
								poll_n = poll_inc;
								if (poll_inc == poll_limit_q) begin
									status_n = 1'b1;
									phase_n  = PH_TRAIL_DONE;
									bits_n   = TRAIL_LEN;
								end else begin
									phase_n = PH_POLL;
									bits_n  = POLL_LEN;
								end
							end
						end
						default: begin
							phase_n = PH_IDLE;
							bits_n  = '0;
							done_n  = 1'b1;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			shift_q  <= '0;
			bits_q   <= '0;
			rx_q     <= '0;
			poll_q   <= '0;
			div_q    <= '0;
			half_q   <= 1'b0;
			status_q <= 1'b0;
			word_q   <= '0;
			op_q     <= OP_TICK;
		end else if (step) begin
			phase_q  <= phase_n;
			shift_q  <= shift_n;
			bits_q   <= bits_n;
			rx_q     <= rx_n;
			poll_q   <= poll_n;
			div_q    <= div_n;
			half_q   <= half_n;
			status_q <= status_n;
			word_q   <= word_n;
			op_q     <= op_n;
		end
	end

	// In the send phase bits_n never exceeds the shift width
	assign mosi_idx = IDX_W'(bits_n - BL_W'(1));

	always_comb begin
		pins_next.busy_res        = (phase_n != PH_IDLE);
		pins_next.chip_select     = (phase_n == PH_SEND) || (phase_n == PH_RECV) ||
		                            (phase_n == PH_POLL);
		pins_next.serial_clock    = (phase_n != PH_IDLE) && half_n;
		pins_next.serial_data_out = (phase_n == PH_SEND) && (bits_n != '0) &&
		                            shift_n[mosi_idx];
		pins_next.done_res        = done_n;
		pins_next.rd_word         = word_n;
		pins_next.status          = status_n;
	end

endmodule

// ===== src/mwire_outreg.sv =====
module mwire_outreg import mwire_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  pins_t pins_next,
	output logic  full_stalled,
	output logic  pin_valid,
	input  logic  pin_stall,
	output pins_t pins
);

	logic  valid_q;
	pins_t pins_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!pin_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pins_q <= pins_next;
		end
	end

	// A new tick may enter when the register is empty or its result leaves in the same cycle
	assign full_stalled = valid_q && pin_stall;
	assign pin_valid    = valid_q;
	assign pins         = pins_q;

endmodule

// ===== src/microwire_eeprom_master_unit.sv =====
// Microwire EEPROM master, one timebase tick per cmd transaction. A tick is taken
// every clock cycle while the result register is free or being emptied, and the
// pin levels and status for that tick appear as a pins transaction on the next
// cycle: one tick per clock, as pins_next is combinational from the sequencer's
// next state and the result register is the single register stage between them.
// Commands are honored only while busy_res is low; the user writes half_bit_ticks
// and busy_poll_limit on the cfg port while idle, which the block does not enforce.
module microwire_eeprom_master_unit import mwire_pkg::*; #(
	parameter int ADDR_BITS       = 8,
	parameter int POLL_GROUP_BITS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  cmd_t       cmd,
	output logic       pin_valid,
	input  logic       pin_stall,
	output pins_t      pins
);

	logic  step;
	pins_t pins_next;

	assign step = cmd_valid && !cmd_stall;

	mwire_seq #(
		.ADDR_BITS       (ADDR_BITS),
		.POLL_GROUP_BITS (POLL_GROUP_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.cmd       (cmd),
		.pins_next (pins_next)
	);

	mwire_outreg u_outreg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.pins_next    (pins_next),
		.full_stalled (cmd_stall),
		.pin_valid    (pin_valid),
		.pin_stall    (pin_stall),
		.pins         (pins)
	);

endmodule

// ===== src/mwire_checker.sv =====
module mwire_checker import mwire_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cmd_stall,
	input logic  pin_valid,
	input logic  pin_stall,
	input pins_t pins
);

	a_pin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pin_valid && pin_stall |=> pin_valid && $stable(pins))
		else $error("pins transaction changed while stalled");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pin_valid && pin_stall |-> cmd_stall)
		else $error("tick accepted while result register is held");

	a_free_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!pin_valid |-> !cmd_stall)
		else $error("tick refused with empty result register");

	a_idle_pins: assert property (@(posedge clk) disable iff (!arst_n)
		pin_valid && !pins.busy_res |->
			!pins.chip_select && !pins.serial_clock && !pins.serial_data_out)
		else $error("serial pins active while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pin_valid && pins.done_res |-> !pins.busy_res)
		else $error("done reported while busy");

endmodule

bind microwire_eeprom_master_unit mwire_checker u_mwire_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_stall (cmd_stall),
	.pin_valid (pin_valid),
	.pin_stall (pin_stall),
	.pins      (pins)
);
